### hw/rtl/ckf_pkg.sv
// ckf_pkg: shared types, codes and helpers for the three-axis constant-velocity filter.
// Used by ckf_mul, ckf_div, ckf_dp, ckf_ctrl and constant_velocity_kalman_3axis.
package ckf_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int AXES_DEF      = 3;
	localparam int DT_BITS       = 16;
	localparam int GAIN_BITS     = 30;
	localparam int MUL_A_W       = 62;
	localparam int MUL_B_W       = 33;
	localparam int MUL_P_W       = MUL_A_W + MUL_B_W;
	localparam int DIV_Q_W       = 62;
	localparam int DIV_D_W       = 34;
	localparam int MUL_STEPS     = MUL_B_W;
	localparam int DIV_STEPS     = DIV_Q_W;

	localparam logic [15:0] STEP_TIME_RST = 16'd2185;
	localparam logic [1:0]  AXIS_Z        = 2'd2;

	localparam logic [2:0] CFG_STEP_TIME   = 3'd0;
	localparam logic [2:0] CFG_INIT_VAR    = 3'd1;
	localparam logic [2:0] CFG_PROC_NOISE  = 3'd2;
	localparam logic [2:0] CFG_MEAS_NOISE  = 3'd3;
	localparam logic [2:0] CFG_DOUBLE_Z    = 3'd4;

	typedef enum logic [3:0] {
		OP_DT2, OP_POS, OP_PPA, OP_PPP, OP_PPV, OP_KP, OP_KV,
		OP_UPOS, OP_UVEL, OP_UCP, OP_UCC, OP_UCV
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RESTART, ST_GO, ST_BUSY, ST_APPLY, ST_OUT
	} state_t;

	typedef struct packed {
		logic       capture;
		logic       restart;
		logic       start;
		logic       apply;
		op_t        op;
		logic [1:0] axis;
	} ckf_ctl_t;

	typedef struct packed {
		logic done;
	} ckf_sts_t;

	function automatic logic signed [31:0] sat_s32(input logic signed [63:0] x);
		if (x > 64'sd2147483647)
			return 32'sh7fffffff;
		else if (x < -64'sd2147483648)
			return 32'sh80000000;
		else
			return x[31:0];
	endfunction

	function automatic logic [31:0] sat_u32(input logic signed [63:0] x);
		if (x < 64'sd0)
			return 32'd0;
		else if (x > 64'sd4294967295)
			return 32'hffffffff;
		else
			return x[31:0];
	endfunction

	function automatic logic [31:0] abs32(input logic signed [31:0] x);
		return x[31] ? (~x + 32'd1) : x;
	endfunction

endpackage

### hw/rtl/ckf_mul.sv
// ckf_mul: shift-add multiplier for unsigned magnitudes, one bit of b per cycle.
// Depends on ckf_pkg for operand widths and step count.
module ckf_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [ckf_pkg::MUL_A_W-1:0]       a,
	input  logic [ckf_pkg::MUL_B_W-1:0]       b,
	output logic                              done,
	output logic [ckf_pkg::MUL_P_W-1:0]       prod
);

	logic                          busy_q;
	logic                          done_q;
	logic [5:0]                    cnt_q;
	logic [ckf_pkg::MUL_B_W-1:0]   b_q;
	logic [ckf_pkg::MUL_P_W-1:0]   acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(ckf_pkg::MUL_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			b_q   <= b;
		end else if (busy_q) begin
			acc_q <= {acc_q[ckf_pkg::MUL_P_W-2:0], 1'b0}
				+ (b_q[ckf_pkg::MUL_B_W-1] ? ckf_pkg::MUL_P_W'(a) : '0);
			b_q   <= {b_q[ckf_pkg::MUL_B_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

### hw/rtl/ckf_div.sv
// ckf_div: restoring divider for gain quotients (num * 2^30 / den), one bit per cycle.
// Depends on ckf_pkg for widths and step count.
module ckf_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [31:0]                   num,
	input  logic [ckf_pkg::DIV_D_W-1:0]   den,
	output logic                          done,
	output logic [ckf_pkg::DIV_Q_W-1:0]   quo
);

	logic                          busy_q;
	logic                          done_q;
	logic [5:0]                    cnt_q;
	logic [ckf_pkg::DIV_Q_W-1:0]   dvd_q;
	logic [ckf_pkg::DIV_Q_W-1:0]   quo_q;
	logic [ckf_pkg::DIV_D_W:0]     rem_q;
	logic [ckf_pkg::DIV_D_W:0]     trial;
	logic                          fits;

	always_comb begin
		trial = {rem_q[ckf_pkg::DIV_D_W-1:0], dvd_q[ckf_pkg::DIV_Q_W-1]};
		fits  = trial >= {1'b0, den};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(ckf_pkg::DIV_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= '0;
			dvd_q <= {num, {ckf_pkg::GAIN_BITS{1'b0}}};
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, den}) : trial;
			quo_q <= {quo_q[ckf_pkg::DIV_Q_W-2:0], fits};
			dvd_q <= {dvd_q[ckf_pkg::DIV_Q_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

### hw/rtl/ckf_dp.sv
// ckf_dp: filter state, temporaries, shared multiplier and divider, per-operation apply.
// Depends on ckf_pkg, ckf_mul and ckf_div; driven by ckf_ctrl commands.
module ckf_dp #(
	parameter int FRAC_BITS = ckf_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ckf_pkg::ckf_ctl_t    ctl,
	output ckf_pkg::ckf_sts_t    sts,
	input  logic [15:0]          step_time,
	input  logic [31:0]          initial_variance,
	input  logic [31:0]          process_noise,
	input  logic [31:0]          measure_noise,
	input  logic                 double_z_noise,
	input  logic signed [31:0]   meas_x,
	input  logic signed [31:0]   meas_y,
	input  logic signed [31:0]   meas_z,
	output logic signed [31:0]   pos_o [3],
	output logic signed [31:0]   vel_o [3]
);

	localparam logic [31:0] VAR_RST = 32'(1) << FRAC_BITS;

	logic signed [31:0] pos_q [3];
	logic signed [31:0] vel_q [3];
	logic signed [31:0] cc_q  [3];
	logic [31:0]        cp_q  [3];
	logic [31:0]        cv_q  [3];
	logic signed [31:0] meas_q [3];

	logic [16:0]        dt2_q;
	logic signed [31:0] p_q;
	logic signed [35:0] ppa_q;
	logic [31:0]        ppp_q;
	logic signed [31:0] ppv_q;
	logic [31:0]        pvv_q;
	logic [ckf_pkg::DIV_Q_W-1:0] kp_q;
	logic signed [62:0] kv_q;
	logic signed [32:0] e_q;
	logic signed [41:0] mres_q;

	logic signed [31:0] cur_pos, cur_vel, cur_cc;
	logic [31:0]        cur_cp, cur_cv;
	logic [ckf_pkg::MUL_A_W-1:0] ma;
	logic [ckf_pkg::MUL_B_W-1:0] mb;
	logic               mneg;
	logic               gain_op;
	logic               div_op;
	logic [ckf_pkg::MUL_P_W-1:0] prod;
	logic               mul_done;
	logic [31:0]        dnum;
	logic [ckf_pkg::DIV_D_W-1:0] den;
	logic               s_zero;
	logic [ckf_pkg::DIV_Q_W-1:0] quo;
	logic               div_done;
	logic [32:0]        e_mag;
	logic [62:0]        kv_mag;
	logic signed [96:0] prod_s;
	logic signed [96:0] rnd16;
	logic signed [96:0] rnd30;
	logic               ovf;
	logic signed [41:0] mres_d;

	always_comb begin
		cur_pos = pos_q[ctl.axis];
		cur_vel = vel_q[ctl.axis];
		cur_cc  = cc_q[ctl.axis];
		cur_cp  = cp_q[ctl.axis];
		cur_cv  = cv_q[ctl.axis];
		e_mag   = e_q[32] ? (~e_q + 33'd1) : e_q;
		kv_mag  = kv_q[62] ? (~kv_q + 63'd1) : kv_q;
		gain_op = (ctl.op == ckf_pkg::OP_UPOS) || (ctl.op == ckf_pkg::OP_UVEL)
			|| (ctl.op == ckf_pkg::OP_UCP) || (ctl.op == ckf_pkg::OP_UCC)
			|| (ctl.op == ckf_pkg::OP_UCV);
		div_op  = (ctl.op == ckf_pkg::OP_KP) || (ctl.op == ckf_pkg::OP_KV);
		den     = {2'b00, ppp_q} + ((double_z_noise && (ctl.axis == ckf_pkg::AXIS_Z))
			? {1'b0, measure_noise, 1'b0} : {2'b00, measure_noise});
		s_zero  = den == '0;
		dnum    = (ctl.op == ckf_pkg::OP_KV) ? ckf_pkg::abs32(ppv_q) : ppp_q;
	end

	always_comb begin
		ma   = '0;
		mb   = '0;
		mneg = 1'b0;
		case (ctl.op)
			ckf_pkg::OP_DT2: begin
				ma = 62'(step_time);
				mb = 33'(step_time);
			end
			ckf_pkg::OP_POS: begin
				ma   = 62'(ckf_pkg::abs32(cur_vel));
				mb   = 33'(step_time);
				mneg = cur_vel[31];
			end
			ckf_pkg::OP_PPA: begin
				ma   = 62'(ckf_pkg::abs32(cur_cc));
				mb   = 33'(step_time);
				mneg = cur_cc[31];
			end
			ckf_pkg::OP_PPP: begin
				ma = 62'(cur_cv);
				mb = 33'(dt2_q);
			end
			ckf_pkg::OP_PPV: begin
				ma = 62'(cur_cv);
				mb = 33'(step_time);
			end
			ckf_pkg::OP_UPOS: begin
				ma   = kp_q;
				mb   = e_mag;
				mneg = e_q[32];
			end
			ckf_pkg::OP_UVEL: begin
				ma   = kv_mag[61:0];
				mb   = e_mag;
				mneg = kv_q[62] ^ e_q[32];
			end
			ckf_pkg::OP_UCP: begin
				ma = kp_q;
				mb = {1'b0, ppp_q};
			end
			ckf_pkg::OP_UCC: begin
				ma   = kp_q;
				mb   = 33'(ckf_pkg::abs32(ppv_q));
				mneg = ppv_q[31];
			end
			ckf_pkg::OP_UCV: begin
				ma   = kv_mag[61:0];
				mb   = 33'(ckf_pkg::abs32(ppv_q));
				mneg = kv_q[62] ^ ppv_q[31];
			end
			default: begin
				ma   = '0;
				mb   = '0;
				mneg = 1'b0;
			end
		endcase
	end

	ckf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.start && !div_op),
		.a      (ma),
		.b      (mb),
		.done   (mul_done),
		.prod   (prod)
	);

	ckf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.start && div_op),
		.num    (dnum),
		.den    (den),
		.done   (div_done),
		.quo    (quo)
	);

	// round to nearest, halves up; gain products saturate past 2^62
	always_comb begin
		prod_s = mneg ? -$signed({2'b00, prod}) : $signed({2'b00, prod});
		rnd16  = (prod_s + 97'sd32768) >>> ckf_pkg::DT_BITS;
		rnd30  = (prod_s + 97'sd536870912) >>> ckf_pkg::GAIN_BITS;
		ovf    = prod > (ckf_pkg::MUL_P_W'(1) << 62);
		if (!gain_op)
			mres_d = rnd16[41:0];
		else if (ovf)
			mres_d = mneg ? -42'sd1099511627776 : 42'sd1099511627776;
		else
			mres_d = rnd30[41:0];
	end

	always_ff @(posedge clk) begin
		if (mul_done)
			mres_q <= mres_d;
		if (ctl.capture) begin
			meas_q[0] <= meas_x;
			meas_q[1] <= meas_y;
			meas_q[2] <= meas_z;
		end
		if (ctl.apply) begin
			case (ctl.op)
				ckf_pkg::OP_DT2: dt2_q <= mres_q[16:0];
				ckf_pkg::OP_POS: p_q <= ckf_pkg::sat_s32(64'(cur_pos) + 64'(mres_q));
				ckf_pkg::OP_PPA: ppa_q <= $signed({4'b0000, cur_cp}) + (36'(mres_q) <<< 1);
				ckf_pkg::OP_PPP: ppp_q <= ckf_pkg::sat_u32(64'(ppa_q) + 64'(mres_q));
				ckf_pkg::OP_PPV: begin
					ppv_q <= ckf_pkg::sat_s32(64'(cur_cc) + 64'(mres_q));
					pvv_q <= ckf_pkg::sat_u32($signed({32'd0, cur_cv})
						+ $signed({32'd0, process_noise}));
				end
				ckf_pkg::OP_KP: begin
					kp_q <= s_zero ? '0 : quo;
					e_q  <= 33'(meas_q[ctl.axis]) - 33'(p_q);
				end
				ckf_pkg::OP_KV: begin
					if (s_zero)
						kv_q <= '0;
					else
						kv_q <= ppv_q[31] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
				cc_q[i]  <= '0;
				cp_q[i]  <= VAR_RST;
				cv_q[i]  <= VAR_RST;
			end
		end else if (ctl.restart) begin
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
				cc_q[i]  <= '0;
				cp_q[i]  <= initial_variance;
				cv_q[i]  <= initial_variance;
			end
		end else if (ctl.apply) begin
			case (ctl.op)
				ckf_pkg::OP_UPOS: pos_q[ctl.axis] <= ckf_pkg::sat_s32(64'(p_q) + 64'(mres_q));
				ckf_pkg::OP_UVEL: vel_q[ctl.axis] <= ckf_pkg::sat_s32(64'(cur_vel)
					+ 64'(mres_q));
				ckf_pkg::OP_UCP: cp_q[ctl.axis] <= ckf_pkg::sat_u32($signed({32'd0, ppp_q})
					- 64'(mres_q));
				ckf_pkg::OP_UCC: cc_q[ctl.axis] <= ckf_pkg::sat_s32(64'(ppv_q) - 64'(mres_q));
				ckf_pkg::OP_UCV: cv_q[ctl.axis] <= ckf_pkg::sat_u32($signed({32'd0, pvv_q})
					- 64'(mres_q));
				default: ;
			endcase
		end
	end

	assign sts.done = mul_done | div_done;
	assign pos_o    = pos_q;
	assign vel_o    = vel_q;

endmodule

### hw/rtl/ckf_ctrl.sv
// ckf_ctrl: sequencer that walks the per-axis operation list and runs the handshakes.
// Depends on ckf_pkg; drives ckf_dp through ckf_ctl_t and reads ckf_sts_t.
module ckf_ctrl #(
	parameter int AXES = ckf_pkg::AXES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_cmd,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	output ckf_pkg::ckf_ctl_t    ctl,
	input  ckf_pkg::ckf_sts_t    sts
);

	ckf_pkg::state_t state_q, state_d;
	ckf_pkg::op_t    op_q, op_d;
	logic [1:0]      axis_q, axis_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ckf_pkg::ST_IDLE;
			op_q    <= ckf_pkg::OP_DT2;
			axis_q  <= '0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			axis_q  <= axis_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		op_d        = op_q;
		axis_d      = axis_q;
		in_stall    = 1'b1;
		out_valid   = 1'b0;
		ctl.capture = 1'b0;
		ctl.restart = 1'b0;
		ctl.start   = 1'b0;
		ctl.apply   = 1'b0;
		ctl.op      = op_q;
		ctl.axis    = axis_q;
		unique case (state_q)
			ckf_pkg::ST_IDLE: begin
				in_stall    = 1'b0;
				ctl.capture = in_valid;
				if (in_valid) begin
					op_d    = ckf_pkg::OP_DT2;
					axis_d  = '0;
					state_d = in_cmd ? ckf_pkg::ST_RESTART : ckf_pkg::ST_GO;
				end
			end
			ckf_pkg::ST_RESTART: begin
				ctl.restart = 1'b1;
				state_d     = ckf_pkg::ST_OUT;
			end
			ckf_pkg::ST_GO: begin
				ctl.start = 1'b1;
				state_d   = ckf_pkg::ST_BUSY;
			end
			ckf_pkg::ST_BUSY: begin
				if (sts.done)
					state_d = ckf_pkg::ST_APPLY;
			end
			ckf_pkg::ST_APPLY: begin
				ctl.apply = 1'b1;
				if (op_q == ckf_pkg::OP_UCV) begin
					if (axis_q == 2'(AXES - 1)) begin
						state_d = ckf_pkg::ST_OUT;
					end else begin
						axis_d  = axis_q + 2'd1;
						op_d    = ckf_pkg::OP_DT2;
						state_d = ckf_pkg::ST_GO;
					end
				end else begin
					op_d    = ckf_pkg::op_t'(op_q + 4'd1);
					state_d = ckf_pkg::ST_GO;
				end
			end
			ckf_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall)
					state_d = ckf_pkg::ST_IDLE;
			end
			default: state_d = ckf_pkg::ST_IDLE;
		endcase
	end

	a_no_accept_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input word accepted while result word pending");

	a_unit_multicycle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |=> !sts.done)
		else $error("arithmetic unit finished in one cycle");

	a_done_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |-> (state_q == ckf_pkg::ST_BUSY))
		else $error("unit done outside busy state");

	a_apply_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.apply |-> $past(state_q) == ckf_pkg::ST_BUSY)
		else $error("apply without completed operation");

endmodule

### hw/rtl/constant_velocity_kalman_3axis.sv
// constant_velocity_kalman_3axis: top level; configuration registers, controller, datapath.
// Depends on ckf_pkg, ckf_ctrl, ckf_dp (with ckf_mul, ckf_div).
//
//   channel   direction  handshake                     word
//   in        input      in_valid / in_stall           cmd, meas_x, meas_y, meas_z
//   out       output     out_valid / out_stall         est_x/y/z, rate_x/y/z
//   cfg       input      cfg_we (no stall)             cfg_index, cfg_data
//
// Update word: per axis, the operation list runs on the bit-serial multiplier (33 steps)
// and divider (62 steps), which all axes share. Restart word: estimates zero, variances
// from init_var. One word in flight; input stalls until the result is taken.
// Reset: estimates zero, variances 1.0, registers at defaults.
module constant_velocity_kalman_3axis #(
	parameter int FRAC_BITS = ckf_pkg::FRAC_BITS_DEF,
	parameter int AXES      = ckf_pkg::AXES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                cmd,
	input  logic signed [31:0]  meas_x,
	input  logic signed [31:0]  meas_y,
	input  logic signed [31:0]  meas_z,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  est_x,
	output logic signed [31:0]  est_y,
	output logic signed [31:0]  est_z,
	output logic signed [31:0]  rate_x,
	output logic signed [31:0]  rate_y,
	output logic signed [31:0]  rate_z,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	logic [15:0] step_time_q;
	logic [31:0] init_var_q;
	logic [31:0] proc_noise_q;
	logic [31:0] meas_noise_q;
	logic        double_z_q;

	ckf_pkg::ckf_ctl_t ctl;
	ckf_pkg::ckf_sts_t sts;
	logic signed [31:0] pos [3];
	logic signed [31:0] vel [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_time_q  <= ckf_pkg::STEP_TIME_RST;
			init_var_q   <= 32'(1) << FRAC_BITS;
			proc_noise_q <= 32'(1) << FRAC_BITS;
			meas_noise_q <= 32'(1) << FRAC_BITS;
			double_z_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ckf_pkg::CFG_STEP_TIME:  step_time_q  <= cfg_data[15:0];
				ckf_pkg::CFG_INIT_VAR:   init_var_q   <= cfg_data;
				ckf_pkg::CFG_PROC_NOISE: proc_noise_q <= cfg_data;
				ckf_pkg::CFG_MEAS_NOISE: meas_noise_q <= cfg_data;
				ckf_pkg::CFG_DOUBLE_Z:   double_z_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	ckf_ctrl #(.AXES(AXES)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_cmd    (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctl       (ctl),
		.sts       (sts)
	);

	ckf_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.sts              (sts),
		.step_time        (step_time_q),
		.initial_variance (init_var_q),
		.process_noise    (proc_noise_q),
		.measure_noise    (meas_noise_q),
		.double_z_noise   (double_z_q),
		.meas_x           (meas_x),
		.meas_y           (meas_y),
		.meas_z           (meas_z),
		.pos_o            (pos),
		.vel_o            (vel)
	);

	assign est_x  = pos[0];
	assign rate_x = vel[0];
	assign est_y  = (AXES > 1) ? pos[1] : '0;
	assign rate_y = (AXES > 1) ? vel[1] : '0;
	assign est_z  = (AXES > 2) ? pos[2] : '0;
	assign rate_z = (AXES > 2) ? vel[2] : '0;

endmodule
